@@ src/bfnp_pkg.sv @@
// ----------------------------------------------------------------------------
// bfnp_pkg
// Shared types and constants for the bounded FIFO with negative purge.
// ----------------------------------------------------------------------------
package bfnp_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 6;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_PURGE   = 2'd2,
        ACT_REVERSE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

endpackage

@@ src/bfnp_if.sv @@
// ----------------------------------------------------------------------------
// bfnp_in_if / bfnp_out_if
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface bfnp_in_if
    import bfnp_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface bfnp_out_if
    import bfnp_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       entry_count;
    logic                     not_empty;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;

    modport source (output valid, output status, output entry_count, output not_empty,
                    output front_value, output rear_value, input ready);
    modport sink   (input valid, input status, input entry_count, input not_empty,
                    input front_value, input rear_value, output ready);
endinterface

@@ src/bfnp_ram.sv @@
// ----------------------------------------------------------------------------
// bfnp_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bfnp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 50
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/bounded_fifo_with_negative_purge.sv @@
// ----------------------------------------------------------------------------
// bounded_fifo_with_negative_purge
// Bounded FIFO of signed words in a circular RAM with purge and reverse.
//
//   channel  dir  payload
//   req      in   action, value
//   rsp      out  status, entry_count, not_empty, front_value, rear_value
//
// Enqueue, reverse, last-entry dequeue, any action on an empty queue: answered from S_IDLE.
// Other dequeues: through S_DEQ_WAIT and S_DONE, waiting on the RAM read of the new front entry.
// Purge: S_PURGE walks the queue, one RAM read and at most one write per entry, then S_DONE.
// Reset is asynchronous; the RAM is not cleared, only live slots are read.
// A stalled rsp holds the result; req is taken again once rsp drains.
// ----------------------------------------------------------------------------
module bounded_fifo_with_negative_purge
    import bfnp_pkg::*;
#(
    parameter int CAPACITY = 50
) (
    input  logic       clk,
    input  logic       rst_n,
    bfnp_in_if.sink    req,
    bfnp_out_if.source rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0]   CAP_X = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ_WAIT,
        S_PURGE,
        S_DONE
    } state_t;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic          rev,
                                              input logic [AW-1:0] pos);
        logic [AW:0] s;
        if (rev)
        begin
            if (head >= pos)
                s = {1'b0, head} - {1'b0, pos};
            else
                s = {1'b0, head} + CAP_X - {1'b0, pos};
        end
        else
        begin
            s = {1'b0, head} + {1'b0, pos};
            if (s >= CAP_X)
                s = s - CAP_X;
        end
        return s[AW-1:0];
    endfunction

    state_t                   state_reg, state_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [CW-1:0]            occ_reg, occ_next;
    logic                     rev_reg, rev_next;
    logic signed [DATA_W-1:0] front_reg, front_next;
    logic signed [DATA_W-1:0] rear_reg, rear_next;
    status_t                  status_reg, status_next;
    logic [CW-1:0]            rd_pos_reg, rd_pos_next;
    logic [CW-1:0]            wr_pos_reg, wr_pos_next;

    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic [COUNT_W-1:0]       out_count_reg, out_count_next;
    logic                     out_nonempty_reg, out_nonempty_next;
    logic signed [DATA_W-1:0] out_front_reg, out_front_next;
    logic signed [DATA_W-1:0] out_rear_reg, out_rear_next;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata, mem_rdata;

    logic out_free;
    logic req_ready;
    logic accept;
    logic emit;

    bfnp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req_ready;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        occ_next    = occ_reg;
        rev_next    = rev_reg;
        front_next  = front_reg;
        rear_next   = rear_reg;
        status_next = status_reg;
        rd_pos_next = rd_pos_reg;
        wr_pos_next = wr_pos_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = req.value;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        emit        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    case (action_t'(req.action))
                        ACT_ENQUEUE:
                        begin
                            if (occ_reg >= CAP_C)
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = slot_of(head_reg, rev_reg, occ_reg[AW-1:0]);
                                mem_wdata = req.value;
                                occ_next  = occ_reg + CW'(1);
                                rear_next = req.value;
                                if (occ_reg == '0)
                                    front_next = req.value;
                            end
                            emit = 1'b1;
                        end
                        ACT_DEQUEUE:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                emit        = 1'b1;
                            end
                            else if (occ_reg == CW'(1))
                            begin
                                occ_next   = '0;
                                head_next  = '0;
                                rev_next   = 1'b0;
                                front_next = '0;
                                rear_next  = '0;
                                emit       = 1'b1;
                            end
                            else
                            begin
                                head_next  = slot_of(head_reg, rev_reg, AW'(1));
                                mem_re     = 1'b1;
                                mem_raddr  = head_next;
                                occ_next   = occ_reg - CW'(1);
                                state_next = S_DEQ_WAIT;
                            end
                        end
                        ACT_PURGE:
                        begin
                            if (occ_reg == '0)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                mem_re      = 1'b1;
                                mem_raddr   = slot_of(head_reg, rev_reg, '0);
                                rd_pos_next = CW'(1);
                                wr_pos_next = '0;
                                state_next  = S_PURGE;
                            end
                        end
                        default:
                        begin
                            if (occ_reg != '0)
                            begin
                                head_next  = slot_of(head_reg, rev_reg,
                                                     occ_reg[AW-1:0] - AW'(1));
                                rev_next   = !rev_reg;
                                front_next = rear_reg;
                                rear_next  = front_reg;
                            end
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_DEQ_WAIT:
            begin
                front_next = mem_rdata;
                state_next = S_DONE;
            end
            S_PURGE:
            begin
                // keep non-negative words, compact toward the front
                if (!mem_rdata[DATA_W-1])
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = slot_of(head_reg, rev_reg, wr_pos_reg[AW-1:0]);
                    mem_wdata   = mem_rdata;
                    wr_pos_next = wr_pos_reg + CW'(1);
                    rear_next   = mem_rdata;
                    if (wr_pos_reg == '0)
                        front_next = mem_rdata;
                end
                if (rd_pos_reg != occ_reg)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = slot_of(head_reg, rev_reg, rd_pos_reg[AW-1:0]);
                    rd_pos_next = rd_pos_reg + CW'(1);
                end
                else
                begin
                    occ_next = wr_pos_next;
                    if (wr_pos_next == '0)
                    begin
                        head_next  = '0;
                        rev_next   = 1'b0;
                        front_next = '0;
                        rear_next  = '0;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_status_next   = out_status_reg;
        out_count_next    = out_count_reg;
        out_nonempty_next = out_nonempty_reg;
        out_front_next    = out_front_reg;
        out_rear_next     = out_rear_reg;
        if (emit)
        begin
            out_valid_next    = 1'b1;
            out_status_next   = status_next;
            out_count_next    = COUNT_W'(occ_next);
            out_nonempty_next = (occ_next != '0);
            out_front_next    = front_next;
            out_rear_next     = rear_next;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_reg         <= '0;
            occ_reg          <= '0;
            rev_reg          <= 1'b0;
            front_reg        <= '0;
            rear_reg         <= '0;
            status_reg       <= ST_OK;
            rd_pos_reg       <= '0;
            wr_pos_reg       <= '0;
            out_valid_reg    <= 1'b0;
            out_status_reg   <= ST_OK;
            out_count_reg    <= '0;
            out_nonempty_reg <= 1'b0;
            out_front_reg    <= '0;
            out_rear_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            occ_reg          <= occ_next;
            rev_reg          <= rev_next;
            front_reg        <= front_next;
            rear_reg         <= rear_next;
            status_reg       <= status_next;
            rd_pos_reg       <= rd_pos_next;
            wr_pos_reg       <= wr_pos_next;
            out_valid_reg    <= out_valid_next;
            out_status_reg   <= out_status_next;
            out_count_reg    <= out_count_next;
            out_nonempty_reg <= out_nonempty_next;
            out_front_reg    <= out_front_next;
            out_rear_reg     <= out_rear_next;
        end
    end

    assign req.ready       = req_ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.not_empty   = out_nonempty_reg;
    assign rsp.front_value = out_front_reg;
    assign rsp.rear_value  = out_rear_reg;

endmodule

@@ bench/bfnp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfnp_checker
// Watches the request and response channels of the bounded FIFO with negative
// purge. Every accepted request beat updates a shadow copy of the circular
// store, head pointer, occupancy and direction flag. The resulting view is
// queued, and each accepted response beat is compared with the oldest entry
// of that queue, field by field.
// ----------------------------------------------------------------------------
module bfnp_checker
    import bfnp_pkg::*;
#(
    parameter int CAPACITY = 50
) (
    input  logic clk,
    input  logic rst_n,
    bfnp_in_if   req,
    bfnp_out_if  rsp,
    output int   fail_count,
    output int   pending,
    output int   beats_checked,
    output int   overflow_hits,
    output int   empty_hits,
    output int   peak_fill
);

    typedef struct packed {
        status_t                  status;
        logic [COUNT_W-1:0]       entry_count;
        logic                     not_empty;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
    } fifo_view_t;

    logic signed [DATA_W-1:0] shadow_ram [CAPACITY];
    int unsigned              head_ptr;
    int unsigned              fill;
    logic                     backward;
    fifo_view_t               view_q [$];

    function automatic int unsigned slot_of_pos(int unsigned pos);
        if (backward)
        begin
            return (head_ptr + CAPACITY - pos) % CAPACITY;
        end
        return (head_ptr + pos) % CAPACITY;
    endfunction

    function automatic fifo_view_t predict_view(action_t act, logic signed [DATA_W-1:0] word);
        fifo_view_t               view;
        int unsigned              rd;
        int unsigned              wr;
        logic signed [DATA_W-1:0] kept;
        view        = '0;
        view.status = ST_OK;
        case (act)
            ACT_ENQUEUE:
            begin
                if (fill >= CAPACITY)
                begin
                    view.status = ST_OVERFLOW;
                end
                else
                begin
                    shadow_ram[slot_of_pos(fill)] = word;
                    fill++;
                end
            end
            ACT_DEQUEUE:
            begin
                if (fill == 0)
                begin
                    view.status = ST_EMPTY;
                end
                else
                begin
                    head_ptr = slot_of_pos(1);
                    fill--;
                end
            end
            ACT_PURGE:
            begin
                wr = 0;
                for (rd = 0; rd < fill; rd++)
                begin
                    kept = shadow_ram[slot_of_pos(rd)];
                    if (!kept[DATA_W-1])
                    begin
                        shadow_ram[slot_of_pos(wr)] = kept;
                        wr++;
                    end
                end
                fill = wr;
            end
            default:
            begin
                if (fill != 0)
                begin
                    head_ptr = slot_of_pos(fill - 1);
                    backward = !backward;
                end
            end
        endcase
        if (fill == 0)
        begin
            head_ptr = 0;
            backward = 1'b0;
        end
        view.entry_count = COUNT_W'(fill);
        view.not_empty   = (fill != 0);
        if (fill != 0)
        begin
            view.front_value = shadow_ram[slot_of_pos(0)];
            view.rear_value  = shadow_ram[slot_of_pos(fill - 1)];
        end
        return view;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        if (fail_count < 30)
        begin
            $display("[%0t] mismatch on response beat %0d, %s: got %0h, expected %0h",
                     $time, beats_checked, what, got, want);
        end
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fifo_view_t want;
        if (!rst_n)
        begin
            head_ptr      = 0;
            fill          = 0;
            backward      = 1'b0;
            view_q.delete();
            fail_count    = 0;
            pending       = 0;
            beats_checked = 0;
            overflow_hits = 0;
            empty_hits    = 0;
            peak_fill     = 0;
        end
        else
        begin
            if (req.valid === 1'b1 && req.ready === 1'b1)
            begin
                view_q.push_back(predict_view(action_t'(req.action), req.value));
            end
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                beats_checked++;
                if (view_q.size() == 0)
                begin
                    report_mismatch("beat with nothing expected", '0, '0);
                end
                else
                begin
                    want = view_q.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.entry_count !== want.entry_count)
                        report_mismatch("entry_count", rsp.entry_count, want.entry_count);
                    if (rsp.not_empty !== want.not_empty)
                        report_mismatch("not_empty", rsp.not_empty, want.not_empty);
                    if (rsp.front_value !== want.front_value)
                        report_mismatch("front_value", rsp.front_value, want.front_value);
                    if (rsp.rear_value !== want.rear_value)
                        report_mismatch("rear_value", rsp.rear_value, want.rear_value);
                    if (want.status == ST_OVERFLOW)
                        overflow_hits++;
                    if (want.status == ST_EMPTY)
                        empty_hits++;
                    if (int'(want.entry_count) > peak_fill)
                        peak_fill = int'(want.entry_count);
                end
            end
            pending = view_q.size();
        end
    end

endmodule

@@ bench/bounded_fifo_with_negative_purge_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_fifo_with_negative_purge_tb
// Drives request beats into the bounded FIFO with negative purge: a short
// directed sequence over the empty, reversed and all-negative cases, then
// random phases that fill the queue to overflow, drain it past empty, churn
// it and purge it. Both channels idle at random, and the response side holds
// off for long stretches so the block backs up. The checker scores every
// response beat.
// ----------------------------------------------------------------------------
module bounded_fifo_with_negative_purge_tb;
    import bfnp_pkg::*;

    localparam int CAPACITY     = 50;
    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   fail_count;
    int   pending;
    int   beats_checked;
    int   overflow_hits;
    int   empty_hits;
    int   peak_fill;
    int   rsp_beats;
    int   purges_sent;
    int   reverses_sent;
    bit   tx_burst;
    bit   rx_burst;

    bfnp_in_if  req ();
    bfnp_out_if rsp ();

    bounded_fifo_with_negative_purge #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    bfnp_checker #(
        .CAPACITY(CAPACITY)
    ) fifo_watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .fail_count   (fail_count),
        .pending      (pending),
        .beats_checked(beats_checked),
        .overflow_hits(overflow_hits),
        .empty_hits   (empty_hits),
        .peak_fill    (peak_fill)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d responses still expected",
                 cycle_count, pending);
        $display("bounded_fifo_with_negative_purge_tb: FAIL");
        $finish;
    end

    function automatic logic signed [DATA_W-1:0] pick_word(int neg_pct);
        logic signed [DATA_W-1:0] w;
        bit                       neg;
        neg = ($urandom_range(0, 99) < neg_pct);
        case ($urandom_range(0, 9))
            0:       w = 32'sh7fff_ffff;
            1:       w = 32'sh8000_0000;
            2:       w = '0;
            3:       w = -32'sd1;
            4, 5:
            begin
                w = $urandom_range(1, 200);
                if (neg)
                    w = -w;
            end
            default:
            begin
                w         = $urandom;
                w[DATA_W-1] = neg;
            end
        endcase
        return w;
    endfunction

    function automatic action_t pick_action(int enq_w, int deq_w, int purge_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < enq_w)
            return ACT_ENQUEUE;
        if (r < enq_w + deq_w)
            return ACT_DEQUEUE;
        if (r < enq_w + deq_w + purge_w)
            return ACT_PURGE;
        return ACT_REVERSE;
    endfunction

    task automatic send_beat(action_t act, logic signed [DATA_W-1:0] w);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid  <= 1'b1;
        req.action <= act;
        req.value  <= w;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        if (act == ACT_PURGE)
            purges_sent++;
        if (act == ACT_REVERSE)
            reverses_sent++;
    endtask

    // response side: random stalls, bursts, and two long hold-offs
    initial
    begin : rsp_drain
        int wait_n;
        rsp.ready <= 1'b0;
        rsp_beats = 0;
        rx_burst  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rsp_beats % 40 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (rsp_beats == 150 || rsp_beats == 650)
                wait_n = HOLD_CYCLES;
            else
                wait_n = rx_burst ? 0 : $urandom_range(0, 13);
            if (wait_n > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp.valid !== 1'b1);
            rsp_beats++;
        end
    end

    initial
    begin : stimulus
        int      sent;
        int      phase_len;
        int      kind;
        int      neg_pct;
        action_t act;
        req.valid     <= 1'b0;
        req.action    <= ACT_ENQUEUE;
        req.value     <= '0;
        tx_burst      = 1'b0;
        purges_sent   = 0;
        reverses_sent = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // empty queue corner cases, extremes, reversed order, full purge
        send_beat(ACT_DEQUEUE, 32'sd9);
        send_beat(ACT_PURGE, '0);
        send_beat(ACT_REVERSE, '0);
        send_beat(ACT_ENQUEUE, 32'sh7fff_ffff);
        send_beat(ACT_ENQUEUE, 32'sh8000_0000);
        send_beat(ACT_ENQUEUE, -32'sd1);
        send_beat(ACT_ENQUEUE, 32'sd0);
        send_beat(ACT_ENQUEUE, 32'sd1);
        send_beat(ACT_REVERSE, '0);
        send_beat(ACT_DEQUEUE, '0);
        send_beat(ACT_ENQUEUE, 32'sd5);
        send_beat(ACT_PURGE, '0);
        send_beat(ACT_REVERSE, '0);
        send_beat(ACT_ENQUEUE, -32'sd7);
        send_beat(ACT_DEQUEUE, '0);
        send_beat(ACT_DEQUEUE, '0);
        send_beat(ACT_DEQUEUE, '0);
        send_beat(ACT_DEQUEUE, '0);
        send_beat(ACT_DEQUEUE, '0);
        send_beat(ACT_ENQUEUE, 32'sd42);
        send_beat(ACT_REVERSE, '0);
        send_beat(ACT_ENQUEUE, -32'sd3);
        send_beat(ACT_PURGE, '0);
        send_beat(ACT_DEQUEUE, '0);
        send_beat(ACT_ENQUEUE, -32'sd5);
        send_beat(ACT_REVERSE, '0);
        send_beat(ACT_PURGE, '0);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            kind     = $urandom_range(0, 3);
            tx_burst = ($urandom_range(0, 3) == 0);
            if (kind == 0)
                phase_len = $urandom_range(60, 90);
            else
                phase_len = $urandom_range(20, 80);
            neg_pct = (kind >= 2) ? 55 : 30;
            repeat (phase_len)
            begin
                case (kind)
                    0:       act = pick_action(90, 4, 3);
                    1:       act = pick_action(10, 80, 5);
                    2:       act = pick_action(35, 35, 15);
                    default: act = pick_action(60, 10, 20);
                endcase
                send_beat(act, pick_word(neg_pct));
                sent++;
            end
        end
        req.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d response beats: %0d overflow drops, %0d empty dequeues, %s",
                 beats_checked, overflow_hits, empty_hits, "queue full and drained");
        $display("peak occupancy %0d of %0d, %0d purges, %0d reversals, two %0d-cycle stalls",
                 peak_fill, CAPACITY, purges_sent, reverses_sent, HOLD_CYCLES);
        if (fail_count == 0)
        begin
            $display("bounded_fifo_with_negative_purge_tb: PASS");
        end
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("bounded_fifo_with_negative_purge_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ bounded_fifo_with_negative_purge.f @@
src/bfnp_pkg.sv
src/bfnp_if.sv
src/bfnp_ram.sv
src/bounded_fifo_with_negative_purge.sv
bench/bfnp_checker.sv
bench/bounded_fifo_with_negative_purge_tb.sv
